>>> rtl/core/pc1_pkg.sv
// shared types and constants of the pc1 stream cipher unit
`timescale 1ns / 1ps

package pc1_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned WORD_WIDTH      = 16;
   localparam int unsigned KEY_HALF_WIDTH  = 64;
   localparam int unsigned KEY_WORDS       = 8;
   localparam int unsigned ROUND_WIDTH     = $clog2(KEY_WORDS);
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 64;

   localparam logic [WORD_WIDTH-1:0] MUL_A = 16'h4E35;
   localparam logic [WORD_WIDTH-1:0] MUL_B = 16'h015A;

   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND = ROUND_WIDTH'(KEY_WORDS - 1);

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION = 2'd2;

   localparam logic DIR_ENCRYPT = 1'b0;

   typedef logic [0:KEY_WORDS-1][WORD_WIDTH-1:0] key_words_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL_AB = 5'b00010,
      ST_MUL_DA = 5'b00100,
      ST_MUL_AA = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

>>> rtl/core/pc1_if.sv
// valid/ready channel interfaces of the pc1 stream cipher unit
`timescale 1ns / 1ps

interface pc1_req_if;
   logic                             valid;
   logic                             ready;
   logic [pc1_pkg::BYTE_WIDTH-1:0]   data_in;
   logic                             start_req;

   modport source (output valid, output data_in, output start_req, input ready);
   modport sink   (input valid, input data_in, input start_req, output ready);
endinterface

interface pc1_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pc1_pkg::BYTE_WIDTH-1:0]   data_out;

   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

interface pc1_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [pc1_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [pc1_pkg::CSR_DATA_WIDTH-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pc1_stream_cipher_128_unit.sv
// pc1 stream cipher with a 128-bit key, one byte per request beat
`timescale 1ns / 1ps

// Usage:
//   req_chan  : one beat per byte, data_in plus start_req; start_req reloads the
//               working key from the key registers and clears the chaining words.
//   rsp_chan  : one beat per request, data_out = data_in xor keystream byte.
//   csr_chan  : register writes (0 key_high, 1 key_low, 2 direction), always ready;
//               write only while no byte is in flight. unknown indexes are dropped.
// Timing:
//   a byte runs on the shared 16x16 multiplier (8 rounds of three
//   products each) plus one finish step; rsp_chan.valid rises and
//   req_chan.ready returns in the same cycle.
//   req_chan.ready is low while a byte is being worked on.
// Stall: the result sits in an output register; a new byte is accepted while
//   it waits, but that byte's finish step holds until the register is free.
// Reset: clears the key registers, working key, chaining words and rsp valid.
module pc1_stream_cipher_128_unit (
   input  logic          clock,
   input  logic          reset,
   pc1_req_if.sink       req_chan,
   pc1_rsp_if.source     rsp_chan,
   pc1_csr_if.sink       csr_chan
);

   localparam int unsigned BW = pc1_pkg::BYTE_WIDTH;
   localparam int unsigned WW = pc1_pkg::WORD_WIDTH;
   localparam int unsigned RW = pc1_pkg::ROUND_WIDTH;

   pc1_pkg::state_type               state_ff, state_in;
   logic [pc1_pkg::KEY_HALF_WIDTH-1:0] key_high_ff, key_high_in;
   logic [pc1_pkg::KEY_HALF_WIDTH-1:0] key_low_ff, key_low_in;
   logic                             direction_ff, direction_in;
   pc1_pkg::key_words_type           key_ff, key_in;
   logic [WW-1:0]                    sum_ff, sum_in;
   logic [WW-1:0]                    chain_ff, chain_in;
   logic [WW-1:0]                    prod_ff, prod_in;
   logic [WW-1:0]                    a_ff, a_in;
   logic [WW-1:0]                    cx_ff, cx_in;
   logic [WW-1:0]                    acc_ff, acc_in;
   logic [RW-1:0]                    round_ff, round_in;
   logic [BW-1:0]                    din_ff, din_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                    rsp_data_ff, rsp_data_in;

   logic [WW-1:0]   ax;
   logic [WW-1:0]   a_cur;
   logic [WW-1:0]   d_cur;
   logic [WW-1:0]   mul_op;
   logic [WW-1:0]   mul_k;
   logic [2*WW-1:0] mul_full;
   logic [WW-1:0]   w_final;
   logic [BW-1:0]   ks;
   logic [BW-1:0]   dout;
   logic [BW-1:0]   mix;
   logic            req_beat;
   logic            out_free;

   assign req_chan.ready    = (state_ff == pc1_pkg::ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.data_out = rsp_data_ff;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // previous round's a-result, still in the product register
   assign ax    = prod_ff + WW'(1);
   assign a_cur = ((round_ff == '0) ? '0 : ax) ^ key_ff[round_ff];
   assign d_cur = chain_ff + WW'(round_ff);

   // shared multiplier operand selection
   always_comb begin
      unique case (state_ff)
         pc1_pkg::ST_MUL_AB: begin
            mul_op = a_cur;
            mul_k  = pc1_pkg::MUL_B;
         end
         pc1_pkg::ST_MUL_DA: begin
            mul_op = d_cur;
            mul_k  = pc1_pkg::MUL_A;
         end
         default: begin
            mul_op = a_ff;
            mul_k  = pc1_pkg::MUL_A;
         end
      endcase
   end

   assign mul_full = mul_op * mul_k;

   assign w_final = acc_ff ^ ax ^ chain_ff;
   assign ks      = w_final[WW-1:BW] ^ w_final[BW-1:0];
   assign dout    = din_ff ^ ks;
   assign mix     = (direction_ff == pc1_pkg::DIR_ENCRYPT) ? din_ff : dout;

   always_comb begin
      key_high_in  = key_high_ff;
      key_low_in   = key_low_ff;
      direction_in = direction_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            pc1_pkg::CSR_KEY_HIGH:  key_high_in  = csr_chan.data;
            pc1_pkg::CSR_KEY_LOW:   key_low_in   = csr_chan.data;
            pc1_pkg::CSR_DIRECTION: direction_in = csr_chan.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      chain_in     = chain_ff;
      prod_in      = prod_ff;
      a_in         = a_ff;
      cx_in        = cx_ff;
      acc_in       = acc_ff;
      round_in     = round_ff;
      din_in       = din_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         pc1_pkg::ST_IDLE: begin
            if (req_beat) begin
               din_in   = req_chan.data_in;
               round_in = '0;
               acc_in   = '0;
               if (req_chan.start_req) begin
                  key_in   = {key_high_ff, key_low_ff};
                  sum_in   = '0;
                  chain_in = '0;
               end
               state_in = pc1_pkg::ST_MUL_AB;
            end
         end
         pc1_pkg::ST_MUL_AB: begin
            a_in    = a_cur;
            prod_in = mul_full[WW-1:0];
            if (round_ff != '0) begin
               acc_in = acc_ff ^ ax ^ chain_ff;
            end
            state_in = pc1_pkg::ST_MUL_DA;
         end
         pc1_pkg::ST_MUL_DA: begin
            // chain needs the old sum, so fold it in before replacing it
            cx_in    = prod_ff + sum_ff;
            sum_in   = prod_ff;
            prod_in  = mul_full[WW-1:0];
            state_in = pc1_pkg::ST_MUL_AA;
         end
         pc1_pkg::ST_MUL_AA: begin
            chain_in = cx_ff + prod_ff;
            prod_in  = mul_full[WW-1:0];
            if (round_ff == pc1_pkg::LAST_ROUND) begin
               state_in = pc1_pkg::ST_FINISH;
            end else begin
               round_in = round_ff + RW'(1);
               state_in = pc1_pkg::ST_MUL_AB;
            end
         end
         pc1_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_data_in  = dout;
               rsp_valid_in = 1'b1;
               key_in       = key_ff ^ {(pc1_pkg::KEY_WORDS * WW / BW){mix}};
               state_in     = pc1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pc1_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pc1_pkg::ST_IDLE;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         direction_ff <= 1'b0;
         key_ff       <= '0;
         sum_ff       <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         direction_ff <= direction_in;
         key_ff       <= key_in;
         sum_ff       <= sum_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      a_ff        <= a_in;
      cx_ff       <= cx_in;
      acc_ff      <= acc_in;
      round_ff    <= round_in;
      din_ff      <= din_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/core/pc1_checker.sv
// port-level checks of the pc1 stream cipher unit, bound to the top level
`timescale 1ns / 1ps

module pc1_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [pc1_pkg::BYTE_WIDTH-1:0] rsp_data,
   input logic                           csr_ready
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp data changed while stalled");

   // one byte at a time: busy right after a request beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !(rsp_valid && $rose(rsp_valid)))
      else $error("request taken while a byte is in flight or result too early");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset left a result pending or input blocked");

   assert property (@(posedge clock) csr_ready)
      else $error("register port not ready");

endmodule

bind pc1_stream_cipher_128_unit pc1_checker u_pc1_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data_out),
   .csr_ready (csr_chan.ready)
);

>>> bench/tb_top.sv
// self-checking bench for the pc1 stream cipher unit: byte messages checked against a predictor
`timescale 1ns / 1ps

module tb_top;

   localparam int BW = pc1_pkg::BYTE_WIDTH;
   localparam int WW = pc1_pkg::WORD_WIDTH;
   localparam int HW = pc1_pkg::KEY_HALF_WIDTH;
   localparam int IW = pc1_pkg::CSR_INDEX_WIDTH;
   localparam int DW = pc1_pkg::CSR_DATA_WIDTH;

   localparam logic [IW-1:0] CSR_SPARE = 2'd3;   // no register behind it
   localparam int HALF_BYTES     = HW / BW;
   localparam int KEY_BYTES      = 2 * HALF_BYTES;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 30;
   localparam int SEGMENTS       = 9;
   localparam int SEGMENT_BYTES  = 148;
   localparam int MAX_SHOWN      = 100;

   // tracks the working key and chaining words, predicts every data_out byte
   class pc1_cipher_board;
      logic [BW-1:0]     work_key [KEY_BYTES];
      logic [WW-1:0]     sum_w;
      logic [WW-1:0]     chain_w;
      logic [HW-1:0]     key_hi;
      logic [HW-1:0]     key_lo;
      logic              decrypt;
      logic [BW-1:0]     predicted_out_bytes [$];
      int                errors;
      int                checked;

      function new();
         foreach (work_key[i]) work_key[i] = '0;
         sum_w   = '0;
         chain_w = '0;
         key_hi  = '0;
         key_lo  = '0;
         decrypt = 1'b0;
         errors  = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] value);
         case (idx)
            pc1_pkg::CSR_KEY_HIGH:  key_hi = value;
            pc1_pkg::CSR_KEY_LOW:   key_lo = value;
            pc1_pkg::CSR_DIRECTION: decrypt = (value[0] != pc1_pkg::DIR_ENCRYPT);
            default: ;
         endcase
      endfunction

      // eight rounds over the key words, folded into one 16-bit word
      function logic [WW-1:0] round_mix_word();
         logic [WW-1:0] prev_a, a, d, na, dx, ax, acc, kw;
         int k;
         prev_a = '0;
         acc    = '0;
         for (k = 0; k < pc1_pkg::KEY_WORDS; k++) begin
            kw = {work_key[2*k], work_key[2*k+1]};
            a  = (k == 0) ? kw : (prev_a ^ kw);
            d  = chain_w + WW'(k);
            na = a * pc1_pkg::MUL_B;
            dx = na + d * pc1_pkg::MUL_A + sum_w;
            ax = a * pc1_pkg::MUL_A + 1'b1;
            sum_w   = na;
            chain_w = dx;
            prev_a  = ax;
            acc     = acc ^ ax ^ dx;
         end
         return acc;
      endfunction

      function void note_request(logic [BW-1:0] din, logic start);
         logic [WW-1:0] w;
         logic [BW-1:0] dout;
         logic [BW-1:0] mix;
         int k;
         if (start) begin
            for (k = 0; k < HALF_BYTES; k++) begin
               work_key[k]            = key_hi[HW-1-BW*k -: BW];
               work_key[HALF_BYTES+k] = key_lo[HW-1-BW*k -: BW];
            end
            sum_w   = '0;
            chain_w = '0;
         end
         w    = round_mix_word();
         dout = din ^ w[WW-1:BW] ^ w[BW-1:0];
         // key mixing always uses the plaintext side
         mix  = decrypt ? dout : din;
         foreach (work_key[i]) work_key[i] = work_key[i] ^ mix;
         predicted_out_bytes.push_back(dout);
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_result(logic [BW-1:0] dout);
         logic [BW-1:0] want;
         checked++;
         if (predicted_out_bytes.size() == 0) begin
            report($sformatf("data_out %02h with no byte outstanding", dout));
         end else begin
            want = predicted_out_bytes.pop_front();
            if (dout !== want) begin
               report($sformatf("data_out %02h, predicted %02h", dout, want));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   pc1_req_if req_chan ();
   pc1_rsp_if rsp_chan ();
   pc1_csr_if csr_chan ();

   pc1_stream_cipher_128_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   pc1_cipher_board board;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;
   int sent_bytes    = 0;
   int settings      = 0;

   always #2 clock = ~clock;

   // every beat on every channel is seen here
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) board.check_result(rsp_chan.data_out);
         if (req_chan.valid && req_chan.ready) board.note_request(req_chan.data_in,
                                                                  req_chan.start_req);
         if (csr_chan.valid && csr_chan.ready) board.write_reg(csr_chan.index, csr_chan.data);
      end
   end

   // receiver: short random stalls plus an occasional long one
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(199) == 0) begin
         hold_left = $urandom_range(10, 60);
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic logic [BW-1:0] random_byte();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return BW'($urandom);
      endcase
   endfunction

   function automatic logic [HW-1:0] random_key_half();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_byte(input logic [BW-1:0] value, input logic start);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 60);
         req_chan.valid   = 1'b0;
         req_chan.data_in = BW'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.data_in   = value;
      req_chan.start_req = start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic write_csr(input logic [IW-1:0] idx, input logic [DW-1:0] value);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic set_key(input logic [HW-1:0] hi,
                          input logic [HW-1:0] lo,
                          input logic [DW-1:0] dir_word);
      write_csr(pc1_pkg::CSR_KEY_HIGH, hi);
      write_csr(pc1_pkg::CSR_KEY_LOW, lo);
      write_csr(pc1_pkg::CSR_DIRECTION, dir_word);
      settings++;
   endtask

   // stop sending and let the unit go idle
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (board.predicted_out_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int seg;
      int len;
      int target;
      board = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_in   = '0;
      req_chan.start_req = 1'b0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 46;

      // bytes with no start since reset run on the all-zero working key
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h5A, 1'b0);
      drain();

      // direction write with upper bits set still means encrypt; spare index is dropped
      set_key('1, '0, 64'hFFFF_FFFF_FFFF_FFFE);
      write_csr(CSR_SPARE, 64'hA5A5_5A5A_0F0F_F0F0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h01, 1'b0);
      drain();

      set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h55, 1'b0);
      drain();

      // new key mid-message waits for the next start, direction applies at once
      write_csr(pc1_pkg::CSR_KEY_LOW, '1);
      write_csr(pc1_pkg::CSR_DIRECTION, 64'd0);
      push_byte(8'h3C, 1'b0);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h7E, 1'b1);
      push_byte(8'h81, 1'b0);
      drain();

      set_key('0, '1, 64'd1);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      drain();

      set_key('0, '0, 64'd0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == SEGMENTS / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 30;
         end else if (seg == 2 * SEGMENTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         case (seg)
            0: set_key('1, '1, {$urandom, $urandom});
            1: set_key('0, '0, {$urandom, $urandom});
            default: set_key(random_key_half(), random_key_half(), {$urandom, $urandom});
         endcase
         if ($urandom_range(3) == 0) write_csr(CSR_SPARE, {$urandom, $urandom});
         target = sent_bytes + SEGMENT_BYTES;
         while (sent_bytes < target) begin
            if ($urandom_range(99) < 85) begin
               // a message: start byte then a run of continuation bytes
               len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
               push_byte(random_byte(), 1'b1);
               repeat (len) push_byte(random_byte(), 1'b0);
            end else begin
               push_byte(random_byte(), 1'($urandom_range(1)));
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d bytes sent under %0d key settings, %0d results checked, %0d bad",
               sent_bytes, settings, board.checked, board.errors);
      $display("summary: both directions, bytes before any start, mid-message writes, spare index");
      if (board.errors == 0 && board.predicted_out_bytes.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

>>> pc1_stream_cipher_128_unit.f
rtl/core/pc1_pkg.sv
rtl/core/pc1_if.sv
rtl/core/pc1_stream_cipher_128_unit.sv
rtl/core/pc1_checker.sv
bench/tb_top.sv
